// ===== src/keyframe_vec3_interpolator_core_assert.svh =====
// assertion macros for the keyframe interpolator
`ifndef KEYFRAME_VEC3_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_VEC3_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KVI_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define KVI_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define KVI_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define KVI_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== src/kvi_pkg.sv =====
// shared types and constants for the keyframe interpolator
`default_nettype none
package kvi_pkg;
    localparam int MaxKeys = 64;
    localparam int FracBits = 16;
    localparam int SlotW = $clog2(MaxKeys);
    localparam int CntW = 7;
    localparam int DivSteps = 32 + FracBits;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_BEFORE = 2'd1, ST_AFTER = 2'd2, ST_EMPTY = 2'd3
    } status_t;
    typedef struct packed {
        logic        action;
        logic [5:0]  slot;
        logic [31:0] ktime;
        logic [95:0] kvec;
        logic [31:0] qtime;
    } item_t;
    typedef enum logic [3:0] {
        B_IDLE, B_DEC, B_RD0, B_RD0W, B_SCAN, B_SCANW, B_RDS, B_RDSW, B_RDE, B_RDEW,
        B_DIV, B_MUL, B_EMIT
    } bstate_t;
endpackage
`default_nettype wire

// ===== src/kvi_ram.sv =====
// generic single port write, single port registered read ram
`default_nettype none
module kvi_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/kvi_front.sv =====
// front end: takes items and queues them, two entries deep
`default_nettype none
module kvi_front import kvi_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       nempty,
    output item_t      head
);
    item_t q_reg [2];
    logic rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    assign full = (cnt_reg == 2'd2);
    assign nempty = (cnt_reg != 2'd0);
    assign head = q_reg[rd_reg];
    always_comb
    begin
        rd_next = rd_reg ^ pop;
        wr_next = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ===== src/kvi_back.sv =====
// back end: key search, restoring divider and per-component interpolation
`default_nettype none
module kvi_back import kvi_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            nempty,
    input  wire item_t           head,
    output logic                 pop,
    input  wire logic [CntW-1:0] key_count,
    output logic                 done,
    output logic [31:0]          value_x,
    output logic [31:0]          value_y,
    output logic [31:0]          value_z,
    output logic [1:0]           status
);
    `include "keyframe_vec3_interpolator_core_assert.svh"
    localparam int IdxW = SlotW + 1;
    bstate_t st_reg, st_next;
    logic [IdxW-1:0] n_reg, idx_reg, idx_next;
    logic [31:0] qt_reg, t0_reg;
    logic [95:0] vs_reg, ve_reg;
    logic [31:0] tread;
    logic [95:0] vread;
    logic [SlotW-1:0] raddr;
    logic [47:0] num_reg, quo_reg;
    logic [32:0] rem_reg, span_reg;
    logic [5:0] step_reg;
    logic [1:0] comp_reg;
    logic [1:0] st_code_reg;
    logic [95:0] res_reg;
    logic we;
    logic [IdxW-1:0] n_sat;
    logic [32:0] rem_sh;
    logic signed [33:0] diff;
    logic signed [FracBits+34:0] prod;
    logic signed [33:0] sval;

    assign we = (st_reg == B_IDLE) && nempty && (head.action == ACT_LOAD);
    assign n_sat = (key_count > CntW'(MaxKeys)) ? IdxW'(MaxKeys) : IdxW'(key_count);

    kvi_ram #(.Width(32), .Depth(MaxKeys)) u_time (
        .clk(clk), .we(we), .waddr(head.slot[SlotW-1:0]), .wdata(head.ktime),
        .raddr(raddr), .rdata(tread)
    );
    kvi_ram #(.Width(96), .Depth(MaxKeys)) u_vec (
        .clk(clk), .we(we), .waddr(head.slot[SlotW-1:0]), .wdata(head.kvec),
        .raddr(raddr), .rdata(vread)
    );

    // read address follows the state
    always_comb
    begin
        case (st_reg)
            B_RD0:   raddr = '0;
            B_RDS:   raddr = idx_reg[SlotW-1:0] - SlotW'(1);
            B_RDE:   raddr = idx_reg[SlotW-1:0];
            default: raddr = idx_reg[SlotW-1:0];
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:  if (nempty) st_next = (head.action == ACT_LOAD) ? B_IDLE : B_DEC;
            B_DEC:   st_next = (n_reg == '0) ? B_EMIT : B_RD0;
            B_RD0:   st_next = B_RD0W;
            B_RD0W:  st_next = (n_reg == IdxW'(1) || qt_reg < tread) ? B_EMIT : B_SCAN;
            B_SCAN:  st_next = (idx_reg >= n_reg) ? B_RDS : B_SCANW;
            B_SCANW: st_next = (qt_reg < tread) ? B_RDS : B_SCAN;
            B_RDS:   st_next = B_RDSW;
            B_RDSW:  st_next = (idx_reg >= n_reg) ? B_EMIT : B_RDE;
            B_RDE:   st_next = B_RDEW;
            B_RDEW:  st_next = B_DIV;
            B_DIV:   st_next = (step_reg == 6'(DivSteps - 1)) ? B_MUL : B_DIV;
            B_MUL:   st_next = (comp_reg == 2'd2) ? B_EMIT : B_MUL;
            B_EMIT:  st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop = (st_reg == B_IDLE) && nempty;
        done = (st_reg == B_EMIT);
        value_x = res_reg[31:0];
        value_y = res_reg[63:32];
        value_z = res_reg[95:64];
        status = st_code_reg;
    end

    always_comb
    begin
        idx_next = idx_reg;
        case (st_reg)
            B_RD0:   idx_next = IdxW'(1);
            B_SCANW: idx_next = (qt_reg < tread) ? idx_reg : idx_reg + IdxW'(1);
            default: idx_next = idx_reg;
        endcase
    end

    assign rem_sh = {rem_reg[31:0], num_reg[47]};
    always_comb
    begin
        case (comp_reg)
            2'd0:
                diff = $signed({ve_reg[31], ve_reg[31:0]})
                     - $signed({vs_reg[31], vs_reg[31:0]});
            2'd1:
                diff = $signed({ve_reg[63], ve_reg[63:32]})
                     - $signed({vs_reg[63], vs_reg[63:32]});
            default:
                diff = $signed({ve_reg[95], ve_reg[95:64]})
                     - $signed({vs_reg[95], vs_reg[95:64]});
        endcase
        prod = $signed({1'b0, quo_reg[FracBits:0]}) * diff;
        case (comp_reg)
            2'd0:    sval = 34'($signed(vs_reg[31:0]));
            2'd1:    sval = 34'($signed(vs_reg[63:32]));
            default: sval = 34'($signed(vs_reg[95:64]));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                qt_reg <= head.qtime;
                n_reg <= n_sat;
                res_reg <= '0;
                st_code_reg <= ST_EMPTY;
            end
            B_DEC:
            begin
                st_code_reg <= (n_reg == '0) ? ST_EMPTY : ST_OK;
            end
            B_RD0W:
            begin
                // key 0 serves both the single key and the before-first case
                res_reg <= vread;
                st_code_reg <= (n_reg == IdxW'(1)) ? ST_OK : ST_BEFORE;
            end
            B_RDSW:
            begin
                vs_reg <= vread;
                t0_reg <= tread;
                res_reg <= vread;
                st_code_reg <= ST_AFTER;
            end
            B_RDEW:
            begin
                ve_reg <= vread;
                span_reg <= {1'b0, tread} - {1'b0, t0_reg};
                num_reg <= {qt_reg - t0_reg, FracBits'(0)};
                rem_reg <= '0;
                step_reg <= '0;
                comp_reg <= '0;
                st_code_reg <= ST_OK;
            end
            B_DIV:
            begin
                num_reg <= {num_reg[46:0], 1'b0};
                step_reg <= step_reg + 6'd1;
                if (rem_sh >= span_reg)
                begin
                    rem_reg <= rem_sh - span_reg;
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
            end
            B_MUL:
            begin
                comp_reg <= comp_reg + 2'd1;
                case (comp_reg)
                    2'd0:    res_reg[31:0] <= 32'(sval + 34'(prod >>> FracBits));
                    2'd1:    res_reg[63:32] <= 32'(sval + 34'(prod >>> FracBits));
                    default: res_reg[95:64] <= 32'(sval + 34'(prod >>> FracBits));
                endcase
            end
            default:
            begin
            end
        endcase
    end

    `KVI_ASSERT_NXT(a_emit_idle, clk, rst_n, st_reg == B_EMIT, st_reg == B_IDLE, "emit to idle")
    `KVI_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, st_reg == B_IDLE, "pop outside idle")
    `KVI_ASSERT_IMP(a_idx_range, clk, rst_n, st_reg == B_RDE, idx_reg < n_reg, "end key range")
endmodule
`default_nettype wire

// ===== src/keyframe_vec3_interpolator_core.sv =====
// top level of the keyframe vector interpolator
//  channel | signals                               | transfer when
//  input   | start busy action key_* query_time    | start && !busy
//  config  | cfg_valid cfg_ready cfg_data          | cfg_valid && cfg_ready
//  result  | done value_x value_y value_z status   | done (one cycle)
// a query runs a linear search over n keys with one ram read per key, then a
// 48-step restoring divide and 3 multiply steps
// loads are written while the back end is idle and give no result
// reset clears key_count and control; key ram content is undefined until loaded
// results cannot be stalled; busy rises only when the two-entry queue is full
`default_nettype none
module keyframe_vec3_interpolator_core import kvi_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [5:0]  key_slot,
    input  wire logic [31:0] key_time,
    input  wire logic [31:0] key_x,
    input  wire logic [31:0] key_y,
    input  wire logic [31:0] key_z,
    input  wire logic [31:0] query_time,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    output logic             done,
    output logic [31:0]      value_x,
    output logic [31:0]      value_y,
    output logic [31:0]      value_z,
    output logic [1:0]       status
);
    `include "keyframe_vec3_interpolator_core_assert.svh"
    logic [CntW-1:0] key_count_reg;
    item_t in_item, head;
    logic full, nempty, pop, push;

    // config is always taken
    assign cfg_ready = 1'b1;
    assign busy = full;
    assign push = start && !full;
    assign in_item = '{action: action, slot: key_slot, ktime: key_time,
                       kvec: {key_z, key_y, key_x}, qtime: query_time};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_count_reg <= cfg_data;
        end
    end

    kvi_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(in_item), .full(full),
        .pop(pop), .nempty(nempty), .head(head)
    );
    kvi_back u_back (
        .clk(clk), .rst_n(rst_n), .nempty(nempty), .head(head), .pop(pop),
        .key_count(key_count_reg), .done(done), .value_x(value_x),
        .value_y(value_y), .value_z(value_z), .status(status)
    );

    `KVI_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push, "push while full")
    `KVI_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done, "done held two cycles")
    `KVI_ASSERT_IMP(a_pop_nempty, clk, rst_n, pop, nempty, "pop from empty queue")
endmodule
`default_nettype wire

// ===== sim/keyframe_vec3_interpolator_core_tb.sv =====
// self-checking testbench for the keyframe vector interpolator core
`default_nettype none
module keyframe_vec3_interpolator_core_tb;
    import kvi_pkg::*;

    // one interpolated vector with its status, as the block should return it
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        status_t     st;
    } track_value_t;

    localparam int SETTLE_CYCLES = 400;  // the worst query searches all 64 keys

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [5:0]  key_slot;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] query_time;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        done;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
    logic [1:0]  status;

    // mirror of the key table and the key_count register
    logic [31:0] time_mirror [MaxKeys];
    logic [31:0] vec_mirror [MaxKeys][3];
    logic [6:0]  count_mirror;

    track_value_t pending_values[$];
    int mismatches = 0;
    int idle_pct = 0;          // chance in percent of a gap before each item
    int items_sent = 0;

    keyframe_vec3_interpolator_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .key_slot(key_slot), .key_time(key_time),
        .key_x(key_x), .key_y(key_y), .key_z(key_z), .query_time(query_time),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .value_x(value_x), .value_y(value_y), .value_z(value_z),
        .status(status)
    );

    always #5 clk = ~clk;

    // interpolated value of the mirrored track at time qt
    function automatic track_value_t interpolate_track(logic [31:0] qt);
        track_value_t r;
        int n;
        int i;
        longint unsigned span;
        longint unsigned offs;
        longint factor;
        longint s;
        longint e;
        logic [31:0] comp [3];
        n = (count_mirror > MaxKeys) ? MaxKeys : int'(count_mirror);
        r.st = ST_OK;
        if (n == 0)
        begin
            r.x = '0; r.y = '0; r.z = '0; r.st = ST_EMPTY;
            return r;
        end
        // single key or time before the first key: key 0 as it is
        if (n == 1 || qt < time_mirror[0])
        begin
            r.x = vec_mirror[0][0]; r.y = vec_mirror[0][1]; r.z = vec_mirror[0][2];
            r.st = (n == 1) ? ST_OK : ST_BEFORE;
            return r;
        end
        // first key whose successor lies later than qt
        i = 0;
        while (i + 1 < n && !(qt < time_mirror[i + 1]))
            i++;
        if (i + 1 >= n)
        begin
            r.x = vec_mirror[n - 1][0]; r.y = vec_mirror[n - 1][1];
            r.z = vec_mirror[n - 1][2]; r.st = ST_AFTER;
            return r;
        end
        span = longint'(time_mirror[i + 1]) - longint'(time_mirror[i]);
        offs = longint'(qt) - longint'(time_mirror[i]);
        factor = longint'((offs << FracBits) / span);
        for (int c = 0; c < 3; c++)
        begin
            s = longint'(signed'(vec_mirror[i][c]));
            e = longint'(signed'(vec_mirror[i + 1][c]));
            // arithmetic shift rounds toward minus infinity
            comp[c] = 32'(s + ((factor * (e - s)) >>> FracBits));
        end
        r.x = comp[0]; r.y = comp[1]; r.z = comp[2];
        return r;
    endfunction

    // drive one item and hold it until the transfer, then update the mirror
    task automatic send_item(input logic act, input logic [5:0] slot,
                             input logic [31:0] kt, input logic [31:0] kx,
                             input logic [31:0] ky, input logic [31:0] kz,
                             input logic [31:0] qt);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        key_slot   <= slot;
        key_time   <= kt;
        key_x      <= kx;
        key_y      <= ky;
        key_z      <= kz;
        query_time <= qt;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (act == ACT_LOAD)
        begin
            time_mirror[slot]   = kt;
            vec_mirror[slot][0] = kx;
            vec_mirror[slot][1] = ky;
            vec_mirror[slot][2] = kz;
        end
        else
        begin
            pending_values.push_back(interpolate_track(qt));
        end
    endtask

    task automatic load_key(input logic [5:0] slot, input logic [31:0] kt,
                            input logic [31:0] kx, input logic [31:0] ky,
                            input logic [31:0] kz);
        send_item(ACT_LOAD, slot, kt, kx, ky, kz, $urandom);
    endtask

    task automatic query_at(input logic [31:0] qt);
        send_item(ACT_QUERY, 6'($urandom), $urandom, $urandom, $urandom, $urandom, qt);
    endtask

    // key_count is written only once the block has drained
    task automatic write_key_count(input logic [6:0] cnt);
        start <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_mirror = cnt;
    endtask

    // ascending track over slots 0..n-1, with an occasional repeated time
    task automatic load_ascending_track(input int n);
        logic [31:0] t;
        t = $urandom_range(0, 1 << 20);
        for (int k = 0; k < n; k++)
        begin
            load_key(6'(k), t, $urandom, $urandom, $urandom);
            if ($urandom_range(9) != 0)
                t = t + $urandom_range(1, (1 << $urandom_range(1, 24)));
        end
    endtask

    // query time near a random key, or anywhere now and then
    function automatic logic [31:0] pick_query_time(input int n);
        int j;
        j = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case ($urandom_range(7))
            0: return $urandom;
            1: return time_mirror[j] - 1;
            2: return time_mirror[j];
            default: return time_mirror[j] + ($urandom & ((1 << $urandom_range(1, 24)) - 1));
        endcase
    endfunction

    always @(posedge clk)
    begin
        track_value_t want;
        if (rst_n && done)
        begin
            if (pending_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h status=%0d",
                             value_x, value_y, value_z, status);
            end
            else
            begin
                want = pending_values.pop_front();
                if (value_x !== want.x || value_y !== want.y || value_z !== want.z ||
                    status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected x=%h y=%h z=%h status=%0d, ",
                                  "got x=%h y=%h z=%h status=%0d"},
                                 want.x, want.y, want.z, want.st,
                                 value_x, value_y, value_z, status);
                end
            end
        end
    end

    task automatic test_empty_track;
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
    endtask

    // every slot gets written once so no later query meets an unwritten key
    task automatic test_fill_table;
        load_ascending_track(MaxKeys);
    endtask

    task automatic test_single_key;
        write_key_count(7'd1);
        query_at(32'h0000_0000);
        query_at(32'hFFFF_FFFF);
    endtask

    // widest span and full-scale vectors in both directions
    task automatic test_two_key_extremes;
        write_key_count(7'd2);
        load_key(6'd0, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        load_key(6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        query_at(32'h0000_0000);   // before first key
        query_at(32'h0000_0001);   // exactly on first key
        query_at(32'h8000_0000);
        query_at(32'hFFFF_FFFE);   // last tick before the end
        query_at(32'hFFFF_FFFF);   // on the last key clamps after
        load_key(6'd1, 32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        query_at(32'h0000_0001);
        load_key(6'd1, 32'h0000_0000, 32'h1234_5678, 32'h0, 32'h0);  // unordered
        query_at(32'h0000_0000);
        query_at(32'h0000_0005);
    endtask

    task automatic test_full_and_oversized_count;
        load_ascending_track(MaxKeys);
        write_key_count(7'd64);
        query_at(pick_query_time(MaxKeys));
        query_at(32'hFFFF_FFFF);
        write_key_count(7'd127);   // clamps to the table size
        query_at(pick_query_time(MaxKeys));
        query_at(32'hFFFF_FFFF);
        write_key_count(7'd0);
        query_at($urandom);
    endtask

    // well-formed tracks with random content, with some unordered noise loads
    task automatic test_random_tracks(input int pct, input int item_goal);
        int n;
        idle_pct = pct;
        while (items_sent < item_goal)
        begin
            case ($urandom_range(9))
                0: n = $urandom_range(0, 1);
                1: n = $urandom_range(65, 127);
                2: n = MaxKeys;
                default: n = $urandom_range(2, 12);
            endcase
            write_key_count(7'(n));
            if (n >= 2)
                load_ascending_track((n > MaxKeys) ? MaxKeys : $urandom_range(2, n));
            if ($urandom_range(3) == 0)
                load_key(6'($urandom), $urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(4, 10))
                query_at(pick_query_time((n > MaxKeys) ? MaxKeys : n));
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= ACT_LOAD;
        key_slot   <= '0;
        key_time   <= '0;
        key_x      <= '0;
        key_y      <= '0;
        key_z      <= '0;
        query_time <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        count_mirror = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_track();
        test_fill_table();
        test_single_key();
        test_two_key_extremes();
        test_full_and_oversized_count();
        test_random_tracks(28, 250);
        test_random_tracks(69, 350);
        test_random_tracks(0, 450);

        start <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
